/* hdl/ftp_upload_session_fsm_top_macros.svh */
// Assertion macros used by the checker file of the upload session block.
`ifndef FTP_UPLOAD_SESSION_FSM_TOP_MACROS_SVH
`define FTP_UPLOAD_SESSION_FSM_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FTPUS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FTPUS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ftpus_pkg.sv */
`timescale 1ns / 1ps

package ftpus_pkg;

  // Event kinds on the input channel
  localparam logic [1:0] OP_REPLY      = 2'd0;
  localparam logic [1:0] OP_TIMEOUT    = 2'd1;
  localparam logic [1:0] OP_FILE_READY = 2'd2;

  // FTP opcodes
  localparam logic [7:0] OPC_TERM    = 8'd1;
  localparam logic [7:0] OPC_WRITE   = 8'd7;
  localparam logic [7:0] OPC_OPEN_WO = 8'd11;
  localparam logic [7:0] OPC_ACK     = 8'd128;
  localparam logic [7:0] OPC_NAK     = 8'd129;

  // Largest payload of one write request
  localparam logic [7:0] CHUNK_CAP = 8'd239;

  // Configuration register indexes
  localparam logic [1:0] CFG_SYS_ID   = 2'd0;
  localparam logic [1:0] CFG_COMP_ID  = 2'd1;
  localparam logic [1:0] CFG_MAX_ATT  = 2'd2;
  localparam logic [1:0] CFG_MAX_CHNK = 2'd3;

  typedef enum logic [1:0] {
    RET_IGNORED = 2'd0,
    RET_HANDLED = 2'd1,
    RET_SENT    = 2'd2
  } ret_code_e;

  typedef enum logic [1:0] {
    SEND_NONE  = 2'd0,
    SEND_OPEN  = 2'd1,
    SEND_WRITE = 2'd2,
    SEND_TERM  = 2'd3
  } send_kind_e;

  typedef enum logic [1:0] {
    NOTIFY_NONE     = 2'd0,
    NOTIFY_PROGRESS = 2'd1,
    NOTIFY_FAILED   = 2'd2,
    NOTIFY_DONE     = 2'd3
  } notify_kind_e;

  typedef enum logic [1:0] {
    TIMER_LEAVE   = 2'd0,
    TIMER_RESTART = 2'd1,
    TIMER_STOP    = 2'd2
  } timer_cmd_e;

  // One event as held in the input register
  typedef struct packed {
    logic [1:0]  op;
    logic        msg_is_ftp;
    logic [7:0]  tgt_sys;
    logic [7:0]  tgt_comp;
    logic [7:0]  req_op;
    logic [7:0]  reply_opcode;
    logic [7:0]  reply_session;
    logic [31:0] file_size;
  } evt_t;

  // One result as held in the output register
  typedef struct packed {
    ret_code_e    ret_code;
    send_kind_e   send_kind;
    logic [15:0]  seq_number;
    logic [7:0]   session_id;
    logic [31:0]  file_offset;
    logic [7:0]   chunk_length;
    notify_kind_e notify_kind;
    logic [31:0]  total_size;
    timer_cmd_e   timer_cmd;
  } res_t;

endpackage

/* hdl/ftp_upload_session_fsm_top.sv */
`timescale 1ns / 1ps

// Client-side upload session controller for file transfer over a telemetry link.
// Input channel (in_valid_i / in_ready_o): one event per request, either an FTP
// reply, a retry timeout or a file-ready notice with the file size.
// Output channel (out_valid_o / out_ready_i): exactly one result per event:
// return code, the request to send (open, write chunk, terminate), a progress
// notification and a retry timer command.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i (own system
// id, own component id, attempt limit, chunk size); write only while idle.
// Each event passes through the input register, then the result register.
// Throughput: one event per cycle while out_ready_i does not stall the output,
// set by the single update pass from the input register to the result register.
// Reset: session returns to idle with all counters cleared and the configuration
// at its defaults; no result is pending.
// Stall: a result waits in the output register while out_ready_i is low; one more
// event may sit in the input register, after which in_ready_o drops.
module ftp_upload_session_fsm_top (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              op_i,
  input  logic                    msg_is_ftp_i,
  input  logic [7:0]              tgt_sys_i,
  input  logic [7:0]              tgt_comp_i,
  input  logic [7:0]              req_op_i,
  input  logic [7:0]              reply_opcode_i,
  input  logic [7:0]              reply_session_i,
  input  logic [31:0]             file_size_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output ftpus_pkg::ret_code_e    ret_code_o,
  output ftpus_pkg::send_kind_e   send_kind_o,
  output logic [15:0]             seq_number_o,
  output logic [7:0]              session_id_o,
  output logic [31:0]             file_offset_o,
  output logic [7:0]              chunk_length_o,
  output ftpus_pkg::notify_kind_e notify_kind_o,
  output logic [31:0]             total_size_o,
  output ftpus_pkg::timer_cmd_e   timer_cmd_o,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [7:0]              cfg_wdata_i
);
  import ftpus_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_OPEN  = 2'd1;
  localparam logic [1:0] PH_WRITE = 2'd2;
  localparam logic [1:0] PH_CLOSE = 2'd3;

  // Configuration registers
  logic [7:0] sys_id_q, comp_id_q, max_chunk_q;
  logic [3:0] max_att_q;

  // Session state
  logic [1:0]  phase_q, phase_d;
  logic [3:0]  att_q, att_d;
  logic [15:0] seq_q, seq_d;
  logic [7:0]  sess_q, sess_d;
  logic [31:0] off_q, off_d;
  logic [31:0] size_q, size_d;
  logic [31:0] rem_q, rem_d;   // bytes left to write, valid while writing

  // Pipeline registers
  logic in_vld_q, out_vld_q;
  evt_t in_q;
  res_t res_q, res_d;

  logic advance, fire;

  // Helper datapath
  logic [7:0]  mc_eff, chunk_cur, chunk_next, chunk_first;
  logic [31:0] rem_next, off_next;
  logic [15:0] seq_inc;
  logic        tgt_match, abandon;
  logic [1:0]  ph_t;

  function automatic logic [7:0] min_chunk(input logic [31:0] rem, input logic [7:0] mc);
    logic [7:0] r;
    r = (rem < {24'd0, mc}) ? rem[7:0] : mc;
    return r;
  endfunction

  // Handshake: advance when the output register is free or being drained
  assign advance    = !out_vld_q || out_ready_i;
  assign fire       = in_vld_q && advance;
  assign in_ready_o = !in_vld_q || advance;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sys_id_q    <= 8'd1;
      comp_id_q   <= 8'd1;
      max_att_q   <= 4'd4;
      max_chunk_q <= CHUNK_CAP;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SYS_ID:   sys_id_q    <= cfg_wdata_i;
        CFG_COMP_ID:  comp_id_q   <= cfg_wdata_i;
        CFG_MAX_ATT:  max_att_q   <= cfg_wdata_i[3:0];
        CFG_MAX_CHNK: max_chunk_q <= cfg_wdata_i;
      endcase
    end
  end

  // Capture the incoming request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q.op            <= op_i;
      in_q.msg_is_ftp    <= msg_is_ftp_i;
      in_q.tgt_sys       <= tgt_sys_i;
      in_q.tgt_comp      <= tgt_comp_i;
      in_q.req_op        <= req_op_i;
      in_q.reply_opcode  <= reply_opcode_i;
      in_q.reply_session <= reply_session_i;
      in_q.file_size     <= file_size_i;
    end
  end

  // Chunk sizing: clamp the limit to 1..239, then take the smaller of limit and remainder
  always_comb begin
    if (max_chunk_q == 8'd0) begin
      mc_eff = 8'd1;
    end else if (max_chunk_q > CHUNK_CAP) begin
      mc_eff = CHUNK_CAP;
    end else begin
      mc_eff = max_chunk_q;
    end
  end

  assign chunk_cur   = min_chunk(rem_q, mc_eff);
  assign chunk_first = min_chunk(size_q, mc_eff);
  assign rem_next    = rem_q - {24'd0, chunk_cur};
  assign off_next    = off_q + {24'd0, chunk_cur};
  assign chunk_next  = min_chunk(rem_next, mc_eff);
  assign seq_inc     = seq_q + 16'd1;
  assign tgt_match   = in_q.msg_is_ftp && (in_q.tgt_sys == sys_id_q) &&
                       (in_q.tgt_comp == comp_id_q);
  assign abandon     = (att_q >= max_att_q);

  // Session update and result for the event in the input register
  always_comb begin
    phase_d = phase_q;
    att_d   = att_q;
    seq_d   = seq_q;
    sess_d  = sess_q;
    off_d   = off_q;
    size_d  = size_q;
    rem_d   = rem_q;
    ph_t    = phase_q;

    res_d.ret_code     = RET_IGNORED;
    res_d.send_kind    = SEND_NONE;
    res_d.seq_number   = 16'd0;
    res_d.session_id   = 8'd0;
    res_d.file_offset  = 32'd0;
    res_d.chunk_length = 8'd0;
    res_d.notify_kind  = NOTIFY_NONE;
    res_d.total_size   = 32'd0;
    res_d.timer_cmd    = TIMER_LEAVE;

    case (in_q.op)
      OP_REPLY: begin
        if (tgt_match) begin
          unique case (phase_q)
            PH_IDLE: begin
            end
            PH_OPEN: begin
              res_d.ret_code = RET_HANDLED;
              if (in_q.req_op == OPC_OPEN_WO) begin
                res_d.timer_cmd = TIMER_STOP;
                if (in_q.reply_opcode == OPC_ACK) begin
                  // Session granted: send the first chunk
                  seq_d   = seq_inc;
                  att_d   = 4'd0;
                  sess_d  = in_q.reply_session;
                  off_d   = 32'd0;
                  rem_d   = size_q;
                  phase_d = PH_WRITE;
                  res_d.ret_code     = RET_SENT;
                  res_d.send_kind    = SEND_WRITE;
                  res_d.seq_number   = seq_inc;
                  res_d.session_id   = in_q.reply_session;
                  res_d.chunk_length = chunk_first;
                  res_d.timer_cmd    = TIMER_RESTART;
                end else if (in_q.reply_opcode == OPC_NAK) begin
                  phase_d = PH_IDLE;
                  res_d.notify_kind = NOTIFY_FAILED;
                end
              end
            end
            PH_WRITE: begin
              if (in_q.req_op == OPC_WRITE) begin
                res_d.timer_cmd = TIMER_STOP;
                if (in_q.reply_opcode == OPC_ACK) begin
                  if (in_q.reply_session == sess_q) begin
                    // Chunk written: advance and send the next chunk or terminate
                    seq_d = seq_inc;
                    att_d = 4'd0;
                    off_d = off_next;
                    rem_d = rem_next;
                    res_d.ret_code    = RET_SENT;
                    res_d.seq_number  = seq_inc;
                    res_d.session_id  = sess_q;
                    res_d.file_offset = off_next;
                    res_d.notify_kind = NOTIFY_PROGRESS;
                    res_d.total_size  = size_q;
                    res_d.timer_cmd   = TIMER_RESTART;
                    if (rem_next == 32'd0) begin
                      phase_d         = PH_CLOSE;
                      res_d.send_kind = SEND_TERM;
                    end else begin
                      res_d.send_kind    = SEND_WRITE;
                      res_d.chunk_length = chunk_next;
                    end
                  end
                end else if (in_q.reply_opcode == OPC_NAK) begin
                  att_d   = 4'd0;
                  phase_d = PH_CLOSE;
                  res_d.ret_code    = RET_SENT;
                  res_d.send_kind   = SEND_TERM;
                  res_d.seq_number  = seq_q;
                  res_d.session_id  = sess_q;
                  res_d.notify_kind = NOTIFY_FAILED;
                  res_d.timer_cmd   = TIMER_RESTART;
                end
              end
            end
            PH_CLOSE: begin
              if (in_q.req_op == OPC_TERM) begin
                res_d.timer_cmd = TIMER_STOP;
                if (in_q.reply_opcode == OPC_ACK) begin
                  res_d.ret_code = RET_HANDLED;
                  if (in_q.reply_session == sess_q) begin
                    res_d.notify_kind = NOTIFY_DONE;
                    phase_d = PH_IDLE;
                  end
                end else if (in_q.reply_opcode == OPC_NAK) begin
                  res_d.ret_code    = RET_HANDLED;
                  res_d.notify_kind = NOTIFY_FAILED;
                  phase_d = PH_IDLE;
                end
              end
            end
          endcase
        end
      end
      OP_TIMEOUT: begin
        res_d.ret_code = RET_HANDLED;
        // Count the attempt, or abandon once the limit is reached
        if (abandon) begin
          res_d.notify_kind = NOTIFY_FAILED;
          if (phase_q == PH_WRITE) begin
            att_d = 4'd0;
            ph_t  = PH_CLOSE;
          end else begin
            ph_t  = PH_IDLE;
          end
        end else if (att_q != 4'hF) begin
          att_d = att_q + 4'd1;
        end
        phase_d = ph_t;
        // Resend the request that belongs to the resulting phase
        unique case (ph_t)
          PH_IDLE: begin
          end
          PH_OPEN: begin
            res_d.ret_code   = RET_SENT;
            res_d.send_kind  = SEND_OPEN;
            res_d.seq_number = seq_q;
            res_d.timer_cmd  = TIMER_RESTART;
          end
          PH_WRITE: begin
            res_d.ret_code     = RET_SENT;
            res_d.send_kind    = SEND_WRITE;
            res_d.seq_number   = seq_q;
            res_d.session_id   = sess_q;
            res_d.file_offset  = off_q;
            res_d.chunk_length = chunk_cur;
            res_d.timer_cmd    = TIMER_RESTART;
          end
          PH_CLOSE: begin
            res_d.ret_code   = RET_SENT;
            res_d.send_kind  = SEND_TERM;
            res_d.seq_number = seq_q;
            res_d.session_id = sess_q;
            res_d.timer_cmd  = TIMER_RESTART;
          end
        endcase
      end
      OP_FILE_READY: begin
        if (phase_q == PH_IDLE) begin
          att_d   = 4'd0;
          size_d  = in_q.file_size;
          phase_d = PH_OPEN;
          res_d.ret_code   = RET_SENT;
          res_d.send_kind  = SEND_OPEN;
          res_d.seq_number = seq_q;
          res_d.timer_cmd  = TIMER_RESTART;
        end
      end
      default: begin
      end
    endcase
  end

  // Commit the session state when the request moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      att_q   <= 4'd0;
      seq_q   <= 16'd0;
      sess_q  <= 8'd0;
      off_q   <= 32'd0;
      size_q  <= 32'd0;
      rem_q   <= 32'd0;
    end else if (fire) begin
      phase_q <= phase_d;
      att_q   <= att_d;
      seq_q   <= seq_d;
      sess_q  <= sess_d;
      off_q   <= off_d;
      size_q  <= size_d;
      rem_q   <= rem_d;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign ret_code_o     = res_q.ret_code;
  assign send_kind_o    = res_q.send_kind;
  assign seq_number_o   = res_q.seq_number;
  assign session_id_o   = res_q.session_id;
  assign file_offset_o  = res_q.file_offset;
  assign chunk_length_o = res_q.chunk_length;
  assign notify_kind_o  = res_q.notify_kind;
  assign total_size_o   = res_q.total_size;
  assign timer_cmd_o    = res_q.timer_cmd;

endmodule

/* hdl/ftpus_chk.sv */
`timescale 1ns / 1ps
`include "ftp_upload_session_fsm_top_macros.svh"

module ftpus_chk (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input ftpus_pkg::ret_code_e    ret_code_o,
  input ftpus_pkg::send_kind_e   send_kind_o,
  input logic [7:0]              session_id_o,
  input logic [31:0]             file_offset_o,
  input logic [7:0]              chunk_length_o,
  input ftpus_pkg::timer_cmd_e   timer_cmd_o
);
  import ftpus_pkg::*;

  // A stalled result stays valid and keeps its request
  `FTPUS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(send_kind_o), "stalled result changed")

  // A request goes out exactly when the return code says so
  `FTPUS_ASSERT_IMP(a_sent_matches, clk_i, rst_ni, out_valid_o, (ret_code_o == RET_SENT) == (send_kind_o != SEND_NONE), "return code and request disagree")

  // The retry timer restarts only together with a request
  `FTPUS_ASSERT_IMP(a_timer_sent, clk_i, rst_ni, out_valid_o && timer_cmd_o == TIMER_RESTART, ret_code_o == RET_SENT, "timer restart without a request")

  // An open carries no session, offset or length
  `FTPUS_ASSERT_IMP(a_open_clean, clk_i, rst_ni, out_valid_o && send_kind_o == SEND_OPEN, session_id_o == 8'd0 && file_offset_o == 32'd0 && chunk_length_o == 8'd0, "open request with write fields")

  // No chunk exceeds the protocol payload
  `FTPUS_ASSERT_IMP(a_chunk_cap, clk_i, rst_ni, out_valid_o, chunk_length_o <= CHUNK_CAP, "chunk over payload limit")

endmodule

bind ftp_upload_session_fsm_top ftpus_chk u_ftpus_chk (.*);
